// ----- hw/rtl/srv_pkg.sv -----
// Shared types and constants of the stacked barcode row validator.
// No dependencies; every other file of the block but srv_ram imports this package.
`timescale 1ns / 1ps

package srv_pkg;

    // Code 128 symbol value
    localparam int CW_W = 7;
    typedef logic [CW_W-1:0] t_cw;

    // Result fields
    typedef logic [3:0] t_status;
    typedef logic [6:0] t_count;

    // Command codes
    typedef logic [1:0] t_cmd;
    localparam t_cmd CMD_CODEWORD   = 2'd0;
    localparam t_cmd CMD_END_ROW    = 2'd1;
    localparam t_cmd CMD_END_SYMBOL = 2'd2;

    // Status codes
    localparam t_status ST_NEW_ROW       = 4'd0;
    localparam t_status ST_DUPLICATE     = 4'd1;
    localparam t_status ST_SHORT         = 4'd2;
    localparam t_status ST_CHECK_BAD     = 4'd3;
    localparam t_status ST_TOO_LONG      = 4'd4;
    localparam t_status ST_SIZE_MISMATCH = 4'd5;
    localparam t_status ST_OK            = 4'd6;
    localparam t_status ST_SIZE_ERROR    = 4'd7;
    localparam t_status ST_UNDER_TWO     = 4'd8;
    localparam t_status ST_BAD_TOTAL     = 4'd9;
    localparam t_status ST_BAD_INDEX     = 4'd10;

    // Row rules
    localparam int MIN_ROW_LEN = 6;

    // Mod-103 reduction: floor(x / 103) = (x * 20361) >> 21, exact for x < 2^14
    localparam int MOD_BASE    = 103;
    localparam int MOD_RECIP   = 20361;
    localparam int MOD_RECIP_W = 15;
    localparam int MOD_SHIFT   = 21;

    // Row and symbol indicator decoding
    localparam t_cw CODE_SET_C = 7'd99;
    localparam int  IDX_OFS_C  = 42;
    localparam int  IDX_SPLIT  = 26;
    localparam int  IDX_OFS_HI = 20;
    localparam int  IDX_OFS_LO = 10;
    localparam int  TOT_OFS_C  = 2;
    localparam int  TOT_SPLIT  = 64;
    localparam int  TOT_OFS_HI = 62;
    localparam int  TOT_OFS_LO = 34;

    // Item as it moves down the pipeline
    typedef struct packed {
        t_cmd              cmd;
        t_cw               cw;
        logic [3*CW_W-1:0] recent;  // last three codewords, newest low
    } t_item;

endpackage

// ----- hw/rtl/srv_in_if.sv -----
// Input channel of the row validator: one command with its codeword per transaction.
// Depends on srv_pkg.
`timescale 1ns / 1ps

interface srv_in_if import srv_pkg::*; ();
    logic valid;
    logic ready;
    t_cmd command;
    t_cw  codeword;

    modport source (output valid, output command, output codeword, input ready);
    modport sink   (input valid, input command, input codeword, output ready);
endinterface

// ----- hw/rtl/srv_out_if.sv -----
// Result channel of the row validator: one status report per transaction.
// Depends on srv_pkg.
`timescale 1ns / 1ps

interface srv_out_if import srv_pkg::*; ();
    logic    valid;
    logic    ready;
    t_status status;
    t_count  row_count;
    t_count  row_length;
    t_cw     check_one;
    t_cw     check_two;

    modport source (output valid, output status, output row_count, output row_length,
                    output check_one, output check_two, input ready);
    modport sink   (input valid, input status, input row_count, input row_length,
                    input check_one, input check_two, output ready);
endinterface

// ----- hw/rtl/stacked_barcode_row_validator_unit.sv -----
// Top level of the stacked barcode row validator.
// Depends on srv_pkg, srv_in_if, srv_out_if, srv_front, srv_issue, srv_ram, srv_row_ctl.
//
// Usage:
//   i_in carries one transaction per item: a command (codeword, end of row,
//   end of symbol) and a 7-bit Code 128 value. Codewords produce no result;
//   each end of row and end of symbol produces one status transaction on o_out.
//   Command code 3 is taken and ignored.
//   Throughput: one transaction per cycle in any mix of commands, while o_out
//   takes its results. A result passes through the accept stage, the memory
//   stage with the row bank RAM read, and the row stage into the output
//   register.
//   The checksum product is multiplied in the accept stage,
//   divided by 103 in the memory stage and summed in the row stage.
//   Rows are kept in one RAM of two banks of MAX_ROW_CODES entries; the bank
//   being filled is written while the last stored row is read for comparison.
//   Reset (i_rst_n low, synchronous, i_in.ready low) clears all control state and
//   starts a new symbol with bank 0 filling; the RAM needs no clearing pass.
//   When o_out stalls with a result waiting, i_in keeps taking transactions
//   until a second result reaches the row stage; then ready drops until the
//   output register empties.
`timescale 1ns / 1ps

module stacked_barcode_row_validator_unit import srv_pkg::*; #(
    parameter int MAX_ROW_CODES = 64,
    parameter int MAX_ROWS      = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    srv_in_if.sink     i_in,
    srv_out_if.source  o_out
);

    localparam int PW  = $clog2(MAX_ROW_CODES + 2);
    localparam int JW  = $clog2(MAX_ROW_CODES);
    localparam int PRW = JW + CW_W;
    localparam int QW  = PRW - 6;
    localparam int AW  = $clog2(2 * MAX_ROW_CODES);

    logic           en;
    logic           bank;
    logic           s1_valid;
    t_item          s1_item;
    logic [PW-1:0]  s1_pos;
    logic [PRW-1:0] s1_prod;
    logic           s2_valid;
    t_item          s2_item;
    logic [PW-1:0]  s2_pos;
    logic [PRW-1:0] s2_prod;
    logic [QW-1:0]  s2_q;
    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    t_cw            ram_wdata;
    logic           ram_re;
    logic [AW-1:0]  ram_raddr;
    t_cw            ram_rdata;

    // Accept stage
    srv_front #(
        .MAX_ROW_CODES(MAX_ROW_CODES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_in       (i_in),
        .o_s1_valid (s1_valid),
        .o_s1_item  (s1_item),
        .o_s1_pos   (s1_pos),
        .o_s1_prod  (s1_prod)
    );

    // Memory stage
    srv_issue #(
        .MAX_ROW_CODES(MAX_ROW_CODES)
    ) u_issue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_s1_valid (s1_valid),
        .i_s1_item  (s1_item),
        .i_s1_pos   (s1_pos),
        .i_s1_prod  (s1_prod),
        .i_bank     (bank),
        .o_we       (ram_we),
        .o_waddr    (ram_waddr),
        .o_wdata    (ram_wdata),
        .o_re       (ram_re),
        .o_raddr    (ram_raddr),
        .o_s2_valid (s2_valid),
        .o_s2_item  (s2_item),
        .o_s2_pos   (s2_pos),
        .o_s2_prod  (s2_prod),
        .o_s2_q     (s2_q)
    );

    // Two row banks
    srv_ram #(
        .WIDTH(CW_W),
        .DEPTH(2 * MAX_ROW_CODES)
    ) u_row_banks (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Row stage and result register
    srv_row_ctl #(
        .MAX_ROW_CODES(MAX_ROW_CODES),
        .MAX_ROWS     (MAX_ROWS)
    ) u_row_ctl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s2_valid (s2_valid),
        .i_s2_item  (s2_item),
        .i_s2_pos   (s2_pos),
        .i_s2_prod  (s2_prod),
        .i_s2_q     (s2_q),
        .i_rdata    (ram_rdata),
        .o_en       (en),
        .o_bank     (bank),
        .o_out      (o_out)
    );

endmodule

// ----- hw/rtl/srv_ram.sv -----
// Generic single-clock RAM: one write port, one read port with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module srv_ram #(
    parameter int WIDTH = 7,
    parameter int DEPTH = 128,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write, then read into the output register
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/srv_front.sv -----
// Accept stage: takes transactions, tracks the row position and the last codewords,
// and forms the checksum product for the previous codeword. Depends on srv_pkg, srv_in_if.
`timescale 1ns / 1ps

module srv_front import srv_pkg::*; #(
    parameter int MAX_ROW_CODES = 64,
    localparam int PW  = $clog2(MAX_ROW_CODES + 2),
    localparam int JW  = $clog2(MAX_ROW_CODES),
    localparam int PRW = JW + CW_W
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    srv_in_if.sink         i_in,
    output logic           o_s1_valid,
    output t_item          o_s1_item,
    output logic [PW-1:0]  o_s1_pos,
    output logic [PRW-1:0] o_s1_prod
);

    localparam logic [PW-1:0] POS_MAX = PW'(MAX_ROW_CODES);
    localparam logic [PW-1:0] POS_OVF = PW'(MAX_ROW_CODES + 1);

    logic              accept;
    logic              known_cmd;
    logic [PW-1:0]     r_pos, n_pos;
    logic [3*CW_W-1:0] r_recent, n_recent;
    logic              r_s1_valid;
    t_item             r_s1_item;
    logic [PW-1:0]     r_s1_pos;
    logic [PRW-1:0]    r_s1_prod;

    // Hold ready low during reset
    assign i_in.ready = i_en && i_rst_n;
    assign accept     = i_in.valid && i_en && i_rst_n;
    assign known_cmd  = (i_in.command == CMD_CODEWORD) || (i_in.command == CMD_END_ROW)
                        || (i_in.command == CMD_END_SYMBOL);

    // Advance position and codeword history
    always_comb begin
        n_pos    = r_pos;
        n_recent = r_recent;
        case (i_in.command)
            CMD_CODEWORD: begin
                if (r_pos >= POS_MAX) begin
                    n_pos = POS_OVF;
                end else begin
                    n_pos    = r_pos + PW'(1);
                    n_recent = {r_recent[2*CW_W-1:0], i_in.codeword};
                end
            end
            CMD_END_ROW, CMD_END_SYMBOL: begin
                n_pos    = '0;
                n_recent = '0;
            end
            default: begin
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_recent   <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (i_en) begin
                r_s1_valid <= accept && known_cmd;
            end
            if (accept) begin
                r_pos    <= n_pos;
                r_recent <= n_recent;
            end
        end
    end

    // Capture the transaction with its weighted product
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_item.cmd    <= i_in.command;
            r_s1_item.cw     <= i_in.codeword;
            r_s1_item.recent <= r_recent;
            r_s1_pos         <= r_pos;
            r_s1_prod        <= PRW'(r_pos[JW-1:0]) * PRW'(r_recent[CW_W-1:0]);
        end
    end

    assign o_s1_valid = r_s1_valid;
    assign o_s1_item  = r_s1_item;
    assign o_s1_pos   = r_s1_pos;
    assign o_s1_prod  = r_s1_prod;

endmodule

// ----- hw/rtl/srv_issue.sv -----
// Memory stage: issues the row bank write and the compare read, and forms the
// mod-103 quotient of the checksum product. Depends on srv_pkg.
`timescale 1ns / 1ps

module srv_issue import srv_pkg::*; #(
    parameter int MAX_ROW_CODES = 64,
    localparam int PW  = $clog2(MAX_ROW_CODES + 2),
    localparam int JW  = $clog2(MAX_ROW_CODES),
    localparam int PRW = JW + CW_W,
    localparam int QW  = PRW - 6,   // quotient by 103 stays below 2^(PRW-6)
    localparam int WW  = PRW + MOD_RECIP_W,
    localparam int AW  = $clog2(2 * MAX_ROW_CODES)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_s1_valid,
    input  t_item          i_s1_item,
    input  logic [PW-1:0]  i_s1_pos,
    input  logic [PRW-1:0] i_s1_prod,
    input  logic           i_bank,
    output logic           o_we,
    output logic [AW-1:0]  o_waddr,
    output t_cw            o_wdata,
    output logic           o_re,
    output logic [AW-1:0]  o_raddr,
    output logic           o_s2_valid,
    output t_item          o_s2_item,
    output logic [PW-1:0]  o_s2_pos,
    output logic [PRW-1:0] o_s2_prod,
    output logic [QW-1:0]  o_s2_q
);

    logic           in_row;
    logic [AW-1:0]  row_ofs;
    logic [WW-1:0]  recip_prod;
    logic           r_s2_valid;
    t_item          r_s2_item;
    logic [PW-1:0]  r_s2_pos;
    logic [PRW-1:0] r_s2_prod;
    logic [QW-1:0]  r_s2_q;

    assign in_row  = i_s1_pos < PW'(MAX_ROW_CODES);
    assign row_ofs = AW'(i_s1_pos[JW-1:0]);

    // Write the codeword to the filling bank, read the stored row at the same place
    assign o_we    = i_en && i_s1_valid && (i_s1_item.cmd == CMD_CODEWORD) && in_row;
    assign o_waddr = i_bank ? AW'(MAX_ROW_CODES) + row_ofs : row_ofs;
    assign o_wdata = i_s1_item.cw;
    assign o_re    = i_en;
    assign o_raddr = i_bank ? row_ofs : AW'(MAX_ROW_CODES) + row_ofs;

    // Quotient by reciprocal multiplication
    assign recip_prod = WW'(i_s1_prod) * WW'(MOD_RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (i_en) begin
            r_s2_valid <= i_s1_valid;
        end
    end

    // Hand the transaction to the row stage
    always_ff @(posedge i_clk) begin
        if (i_en && i_s1_valid) begin
            r_s2_item <= i_s1_item;
            r_s2_pos  <= i_s1_pos;
            r_s2_prod <= i_s1_prod;
            r_s2_q    <= recip_prod[MOD_SHIFT +: QW];
        end
    end

    assign o_s2_valid = r_s2_valid;
    assign o_s2_item  = r_s2_item;
    assign o_s2_pos   = r_s2_pos;
    assign o_s2_prod  = r_s2_prod;
    assign o_s2_q     = r_s2_q;

endmodule

// ----- hw/rtl/srv_row_ctl.sv -----
// Row stage: checksum accumulation, row and symbol checks, symbol state and the
// result register. Depends on srv_pkg, srv_out_if.
`timescale 1ns / 1ps

module srv_row_ctl import srv_pkg::*; #(
    parameter int MAX_ROW_CODES = 64,
    parameter int MAX_ROWS      = 64,
    localparam int PW  = $clog2(MAX_ROW_CODES + 2),
    localparam int JW  = $clog2(MAX_ROW_CODES),
    localparam int PRW = JW + CW_W,
    localparam int QW  = PRW - 6,
    localparam int LW  = $clog2(MAX_ROW_CODES + 1),
    localparam int RW  = $clog2(MAX_ROWS + 1)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s2_valid,
    input  t_item          i_s2_item,
    input  logic [PW-1:0]  i_s2_pos,
    input  logic [PRW-1:0] i_s2_prod,
    input  logic [QW-1:0]  i_s2_q,
    input  t_cw            i_rdata,
    output logic           o_en,
    output logic           o_bank,
    srv_out_if.source      o_out
);

    // Symbol and row state
    logic            r_bank, n_bank;
    t_cw             r_acc, n_acc;
    logic            r_differs, n_differs;
    logic [RW-1:0]   r_rows, n_rows;
    logic [LW-1:0]   r_first_len, n_first_len;
    logic [2*CW_W-1:0] r_first_ind, n_first_ind;
    logic            r_err_size, n_err_size;
    logic            r_err_index, n_err_index;
    logic [2*CW_W-1:0] r_kept, n_kept;
    logic [2*CW_W-1:0] r_head, n_head;

    // Result register
    logic            r_out_valid;
    t_status         r_out_status;
    t_count          r_out_count;
    t_count          r_out_length;
    logic [2*CW_W-1:0] r_out_kept;

    logic            en;
    logic            has_result;
    logic            in_row;
    logic            overflow;
    logic [LW-1:0]   len;
    logic [PRW-1:0]  qx103;
    logic [PRW-1:0]  rem_full;
    logic [CW_W:0]   acc_sum;
    t_cw             acc_next;
    t_cw             last_cw;
    t_cw             head_sel;
    t_cw             head_val;
    t_cw             first_sel;
    t_cw             first_val;
    logic [7:0]      idx_ext;
    logic [7:0]      cnt_ext;
    logic            idx_ok;
    logic            tot_ok;
    logic            row_store;
    t_status         res_status;
    t_count          res_count;
    t_count          res_length;
    logic [2*CW_W-1:0] res_kept;

    // Stall only when a result cannot leave
    assign has_result = i_s2_valid && ((i_s2_item.cmd == CMD_END_ROW)
                        || (i_s2_item.cmd == CMD_END_SYMBOL));
    assign en         = !(has_result && r_out_valid && !o_out.ready);

    // Reduce the product and add it to the running sum
    assign qx103    = PRW'(i_s2_q) * PRW'(MOD_BASE);
    assign rem_full = i_s2_prod - qx103;
    assign acc_sum  = {1'b0, r_acc} + {1'b0, rem_full[CW_W-1:0]};
    assign acc_next = (acc_sum >= (CW_W+1)'(MOD_BASE)) ?
                      CW_W'(acc_sum - (CW_W+1)'(MOD_BASE)) : acc_sum[CW_W-1:0];

    assign in_row   = i_s2_pos < PW'(MAX_ROW_CODES);
    assign overflow = i_s2_pos > PW'(MAX_ROW_CODES);
    assign len      = overflow ? LW'(MAX_ROW_CODES) : LW'(i_s2_pos);
    assign last_cw  = i_s2_item.recent[CW_W-1:0];

    // Row index indicator of the row being ended
    assign head_sel = r_head[2*CW_W-1:CW_W];
    assign head_val = r_head[CW_W-1:0];
    assign idx_ext  = 8'(r_rows);
    always_comb begin
        if (head_sel == CODE_SET_C) begin
            idx_ok = {1'b0, head_val} == idx_ext + 8'(IDX_OFS_C);
        end else if (head_val >= CW_W'(IDX_SPLIT)) begin
            idx_ok = {1'b0, head_val} == idx_ext + 8'(IDX_OFS_HI);
        end else begin
            idx_ok = {1'b0, head_val} == idx_ext + 8'(IDX_OFS_LO);
        end
    end

    // Row total indicator of the first row
    assign first_sel = r_first_ind[2*CW_W-1:CW_W];
    assign first_val = r_first_ind[CW_W-1:0];
    assign cnt_ext   = 8'(r_rows);
    always_comb begin
        if (first_sel == CODE_SET_C) begin
            tot_ok = {1'b0, first_val} + 8'(TOT_OFS_C) == cnt_ext;
        end else if (first_val >= CW_W'(TOT_SPLIT)) begin
            tot_ok = {1'b0, first_val} == cnt_ext + 8'(TOT_OFS_HI);
        end else begin
            tot_ok = {1'b0, first_val} + 8'(TOT_OFS_LO) == cnt_ext;
        end
    end

    // Per-transaction update of the row and symbol state
    always_comb begin
        n_bank      = r_bank;
        n_acc       = r_acc;
        n_differs   = r_differs;
        n_rows      = r_rows;
        n_first_len = r_first_len;
        n_first_ind = r_first_ind;
        n_err_size  = r_err_size;
        n_err_index = r_err_index;
        n_kept      = r_kept;
        n_head      = r_head;
        row_store   = 1'b0;
        res_status  = ST_OK;
        res_count   = 7'(r_rows);
        res_length  = 7'(r_first_len);
        res_kept    = r_kept;
        if (i_s2_valid) begin
            case (i_s2_item.cmd)
                CMD_CODEWORD: begin
                    if (in_row) begin
                        if (i_s2_pos != '0) begin
                            n_acc = acc_next;
                        end
                        if ((r_rows != '0) && (i_s2_pos < PW'(r_first_len))
                            && (i_rdata != i_s2_item.cw)) begin
                            n_differs = 1'b1;
                        end
                        if (i_s2_pos == PW'(0)) begin
                            n_head[2*CW_W-1:CW_W] = i_s2_item.cw;
                        end
                        if (i_s2_pos == PW'(1)) begin
                            n_head[CW_W-1:0] = i_s2_item.cw;
                        end
                    end
                end
                CMD_END_ROW: begin
                    if (overflow) begin
                        res_status = ST_TOO_LONG;
                    end else if (len < LW'(MIN_ROW_LEN)) begin
                        res_status = ST_SHORT;
                    end else if (r_acc != last_cw) begin
                        res_status = ST_CHECK_BAD;
                    end else if (r_rows == '0) begin
                        n_first_len = len;
                        n_first_ind = r_head;
                        row_store   = 1'b1;
                    end else if (!r_differs && (len == r_first_len)) begin
                        n_kept     = i_s2_item.recent[3*CW_W-1:CW_W];
                        res_status = ST_DUPLICATE;
                    end else if (len != r_first_len) begin
                        n_err_size = 1'b1;
                        res_status = ST_SIZE_MISMATCH;
                    end else if (r_rows >= RW'(MAX_ROWS)) begin
                        n_err_size = 1'b1;
                        res_status = ST_TOO_LONG;
                    end else begin
                        if (!idx_ok) begin
                            n_err_index = 1'b1;
                        end
                        row_store = 1'b1;
                    end
                    if (row_store) begin
                        n_rows     = r_rows + RW'(1);
                        n_bank     = ~r_bank;
                        n_kept     = i_s2_item.recent[3*CW_W-1:CW_W];
                        res_status = ST_NEW_ROW;
                    end
                    res_count  = 7'(n_rows);
                    res_length = 7'(len);
                    res_kept   = n_kept;
                    n_acc      = '0;
                    n_differs  = 1'b0;
                end
                CMD_END_SYMBOL: begin
                    if (r_err_size) begin
                        res_status = ST_SIZE_ERROR;
                    end else if (r_rows < RW'(2)) begin
                        res_status = ST_UNDER_TWO;
                    end else if (!tot_ok) begin
                        res_status = ST_BAD_TOTAL;
                    end else if (r_err_index) begin
                        res_status = ST_BAD_INDEX;
                    end else begin
                        res_status = ST_OK;
                    end
                    n_acc       = '0;
                    n_differs   = 1'b0;
                    n_rows      = '0;
                    n_first_len = '0;
                    n_first_ind = '0;
                    n_err_size  = 1'b0;
                    n_err_index = 1'b0;
                    n_kept      = '0;
                end
                default: begin
                end
            endcase
        end
    end

    // Commit state when the pipeline advances
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank      <= 1'b0;
            r_acc       <= '0;
            r_differs   <= 1'b0;
            r_rows      <= '0;
            r_first_len <= '0;
            r_first_ind <= '0;
            r_err_size  <= 1'b0;
            r_err_index <= 1'b0;
            r_kept      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (en) begin
                r_bank      <= n_bank;
                r_acc       <= n_acc;
                r_differs   <= n_differs;
                r_rows      <= n_rows;
                r_first_len <= n_first_len;
                r_first_ind <= n_first_ind;
                r_err_size  <= n_err_size;
                r_err_index <= n_err_index;
                r_kept      <= n_kept;
            end
            if (en && has_result) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the row head and the result payload
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_head <= n_head;
        end
        if (en && has_result) begin
            r_out_status <= res_status;
            r_out_count  <= res_count;
            r_out_length <= res_length;
            r_out_kept   <= res_kept;
        end
    end

    assign o_en             = en;
    assign o_bank           = n_bank;
    assign o_out.valid      = r_out_valid;
    assign o_out.status     = r_out_status;
    assign o_out.row_count  = r_out_count;
    assign o_out.row_length = r_out_length;
    assign o_out.check_one  = r_out_kept[2*CW_W-1:CW_W];
    assign o_out.check_two  = r_out_kept[CW_W-1:0];

    // Checksum accumulator stays reduced
    a_acc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acc < CW_W'(MOD_BASE))
        else $error("checksum accumulator out of mod-103 range");

    // Bank flips only with a newly stored row
    a_bank_flip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bank != $past(r_bank)) |-> (r_rows == $past(r_rows) + RW'(1)))
        else $error("row bank switched without storing a row");

    // Index errors come only from rows after the first
    a_index_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err_index |-> (r_rows >= RW'(2)))
        else $error("bad index flag set with fewer than two rows");

    // Stored row count within capacity
    a_rows_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rows <= RW'(MAX_ROWS))
        else $error("stored row count above capacity");

endmodule

// ----- dv/stacked_barcode_row_validator_unit_tb.sv -----
// Self-checking testbench for the stacked barcode row validator: it scans symbols row by
// row and checks every status transaction against a cycle-free model of the row checks.
// Depends on srv_pkg, srv_in_if, srv_out_if and stacked_barcode_row_validator_unit.
`timescale 1ns / 1ps

module stacked_barcode_row_validator_unit_tb;
    import srv_pkg::*;

    localparam int   ROW_CODES        = 64;
    localparam int   ROW_LIMIT        = 64;
    localparam t_cmd CMD_UNUSED       = 2'd3;
    localparam int   CYCLE_LIMIT      = 1000000;
    localparam int   DRAIN_CYCLES     = 12;
    localparam int   LONG_HOLD_CYCLES = 250;
    localparam int   RANDOM_ITEMS     = 730;

    typedef t_cw t_code_q[$];

    typedef struct packed {
        t_status status;
        t_count  row_count;
        t_count  row_length;
        t_cw     check_one;
        t_cw     check_two;
    } t_report;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    srv_in_if  in_ch ();
    srv_out_if out_ch ();

    stacked_barcode_row_validator_unit #(
        .MAX_ROW_CODES (ROW_CODES),
        .MAX_ROWS      (ROW_LIMIT)
    ) DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Free-running clock, 8 ns period
    always begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    t_report pending_reports[$];
    int      mismatch_count = 0;
    int      accepted_items = 0;
    bit      in_idle_on = 1'b1;
    bit      out_idle_on = 1'b1;
    bit      long_hold_req = 1'b0;
    bit      out_hold = 1'b0;

    // ---------------------------------------------------------------
    // Row check model: its own copy of the banks and symbol state
    // ---------------------------------------------------------------
    t_cw         row_mem [2][ROW_CODES];
    bit          fill_bank;
    int unsigned code_count;
    int unsigned weighted_acc;
    logic [20:0] last_codes;
    bit          row_differs;
    int unsigned rows_kept;
    int unsigned first_width;
    t_cw         first_set_code;
    t_cw         first_row_ind;
    bit          size_error;
    bit          index_error;
    t_cw         k1_held;
    t_cw         k2_held;

    function automatic void clear_row_state();
        code_count   = 0;
        weighted_acc = 0;
        last_codes   = '0;
        row_differs  = 1'b0;
    endfunction

    function automatic void clear_symbol_state();
        clear_row_state();
        rows_kept      = 0;
        first_width    = 0;
        first_set_code = '0;
        first_row_ind  = '0;
        size_error     = 1'b0;
        index_error    = 1'b0;
        k1_held        = '0;
        k2_held        = '0;
    endfunction

    function automatic bit row_index_good(t_cw set_code, t_cw ind, int unsigned idx);
        int v;
        v = ind;
        if (set_code == CODE_SET_C)
            return v - IDX_OFS_C == int'(idx);
        if (v >= IDX_SPLIT)
            return v - IDX_OFS_HI == int'(idx);
        return v - IDX_OFS_LO == int'(idx);
    endfunction

    function automatic bit symbol_total_good(t_cw set_code, t_cw ind, int unsigned n);
        int v;
        v = ind;
        if (set_code == CODE_SET_C)
            return v + TOT_OFS_C == int'(n);
        if (v >= TOT_SPLIT)
            return v - TOT_OFS_HI == int'(n);
        return v + TOT_OFS_LO == int'(n);
    endfunction

    // Store a codeword, extend the running sum and compare with the last stored row
    function automatic void absorb_codeword(t_cw cw);
        if (code_count >= ROW_CODES) begin
            code_count = ROW_CODES + 1;
            return;
        end
        if (code_count >= 1)
            weighted_acc = (weighted_acc + code_count * last_codes[6:0]) % MOD_BASE;
        row_mem[fill_bank][code_count] = cw;
        if (rows_kept > 0 && code_count < first_width &&
            row_mem[fill_bank ^ 1'b1][code_count] != cw)
            row_differs = 1'b1;
        last_codes = {last_codes[13:0], cw};
        code_count++;
    endfunction

    // Decide the fate of the row just ended
    function automatic t_status close_row();
        if (code_count > ROW_CODES)
            return ST_TOO_LONG;
        if (code_count < MIN_ROW_LEN)
            return ST_SHORT;
        if (weighted_acc != last_codes[6:0])
            return ST_CHECK_BAD;
        if (rows_kept == 0) begin
            first_width    = code_count;
            first_set_code = row_mem[fill_bank][0];
            first_row_ind  = row_mem[fill_bank][1];
        end else if (!row_differs && code_count == first_width) begin
            {k1_held, k2_held} = last_codes[20:7];
            return ST_DUPLICATE;
        end else if (code_count != first_width) begin
            size_error = 1'b1;
            return ST_SIZE_MISMATCH;
        end else if (rows_kept >= ROW_LIMIT) begin
            size_error = 1'b1;
            return ST_TOO_LONG;
        end else if (!row_index_good(row_mem[fill_bank][0], row_mem[fill_bank][1],
                                     rows_kept)) begin
            index_error = 1'b1;
        end
        rows_kept++;
        fill_bank = fill_bank ^ 1'b1;
        {k1_held, k2_held} = last_codes[20:7];
        return ST_NEW_ROW;
    endfunction

    function automatic t_status close_symbol();
        if (size_error)
            return ST_SIZE_ERROR;
        if (rows_kept < 2)
            return ST_UNDER_TWO;
        if (!symbol_total_good(first_set_code, first_row_ind, rows_kept))
            return ST_BAD_TOTAL;
        if (index_error)
            return ST_BAD_INDEX;
        return ST_OK;
    endfunction

    // Advance the model by one accepted transaction and queue its report
    function automatic void predict_transaction(t_cmd cmd, t_cw cw);
        t_report     rep;
        int unsigned len;
        case (cmd)
            CMD_CODEWORD: absorb_codeword(cw);
            CMD_END_ROW: begin
                len = (code_count > ROW_CODES) ? ROW_CODES : code_count;
                rep.status     = close_row();
                rep.row_count  = t_count'(rows_kept);
                rep.row_length = t_count'(len);
                rep.check_one  = k1_held;
                rep.check_two  = k2_held;
                pending_reports = {pending_reports, rep};
                clear_row_state();
            end
            CMD_END_SYMBOL: begin
                rep.status     = close_symbol();
                rep.row_count  = t_count'(rows_kept);
                rep.row_length = t_count'(first_width);
                rep.check_one  = k1_held;
                rep.check_two  = k2_held;
                pending_reports = {pending_reports, rep};
                clear_symbol_state();
            end
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Result side: ready driver, long hold-off and checker
    // ---------------------------------------------------------------

    // Drive ready at the falling edge; stall in random bursts
    initial begin : drive_out_ready
        int stall_left;
        stall_left = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (stall_left == 0 && out_idle_on && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 10);
            out_ch.ready = !(out_hold || stall_left > 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    // Hold the result channel off for one long stretch once requested
    initial begin : long_hold
        wait (long_hold_req);
        @(posedge clk);
        out_hold = 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        out_hold = 1'b0;
    end

    task automatic flag_mismatch(string what, t_report want, t_report got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("[%0t] %s: expected st %0d rows %0d len %0d k1 %0d k2 %0d",
                     $time, what, want.status, want.row_count, want.row_length,
                     want.check_one, want.check_two);
            $display("[%0t] %s: got st %0d rows %0d len %0d k1 %0d k2 %0d",
                     $time, what, got.status, got.row_count, got.row_length,
                     got.check_one, got.check_two);
        end
    endtask

    // Compare every result transaction with the oldest queued report
    always @(posedge clk) begin : check_reports
        t_report got;
        t_report want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            got = '{out_ch.status, out_ch.row_count, out_ch.row_length,
                    out_ch.check_one, out_ch.check_two};
            if (pending_reports.size() == 0) begin
                flag_mismatch("unexpected report", '0, got);
            end else begin
                want = pending_reports.pop_front();
                if (got.status !== want.status || got.row_count !== want.row_count ||
                    got.row_length !== want.row_length ||
                    got.check_one !== want.check_one || got.check_two !== want.check_two)
                    flag_mismatch("report mismatch", want, got);
            end
        end
    end

    // End the run if it hangs
    initial begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("stacked_barcode_row_validator_unit_tb failed");
        $finish;
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    // Offer one transaction from a falling edge, wait for it to be taken
    task automatic send_item(t_cmd cmd, t_cw cw);
        if (in_idle_on && $urandom_range(0, 4) == 0) begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        in_ch.valid    = 1'b1;
        in_ch.command  = cmd;
        in_ch.codeword = cw;
        do
            @(posedge clk);
        while (!in_ch.ready);
        predict_transaction(cmd, cw);
        if (cmd != CMD_UNUSED)
            accepted_items++;
        @(negedge clk);
    endtask

    function automatic t_cw rand_code();
        if ($urandom_range(0, 15) == 0)
            return t_cw'($urandom_range(106, 127));
        return t_cw'($urandom_range(0, 105));
    endfunction

    function automatic t_cw pick_set();
        if ($urandom_range(0, 1))
            return CODE_SET_C;
        return t_cw'($urandom_range(0, 127));
    endfunction

    function automatic t_cw weighted_sum(t_code_q codes);
        int unsigned acc;
        acc = 0;
        foreach (codes[i])
            acc = (acc + (i + 1) * codes[i]) % MOD_BASE;
        return t_cw'(acc);
    endfunction

    // Row indicator that matches row number idx under the given code set
    function automatic t_cw index_code(t_cw set_code, int idx);
        if (set_code == CODE_SET_C)
            return t_cw'(idx + IDX_OFS_C);
        if (idx < IDX_SPLIT - IDX_OFS_LO &&
            (idx < IDX_SPLIT - IDX_OFS_HI || $urandom_range(0, 1)))
            return t_cw'(idx + IDX_OFS_LO);
        return t_cw'(idx + IDX_OFS_HI);
    endfunction

    // First-row indicator that announces n rows
    function automatic t_cw total_code(t_cw set_code, int n);
        if (set_code == CODE_SET_C)
            return t_cw'(n - TOT_OFS_C);
        if (n >= TOT_OFS_LO && $urandom_range(0, 1))
            return t_cw'(n - TOT_OFS_LO);
        return t_cw'(n + TOT_OFS_HI);
    endfunction

    // Selector, indicator, random data, then the mod-103 check codeword
    function automatic t_code_q build_row(t_cw set_code, t_cw indicator, int width);
        t_code_q codes;
        codes = {codes, set_code};
        codes = {codes, indicator};
        while (codes.size() < width - 1)
            codes = {codes, rand_code()};
        codes = {codes, weighted_sum(codes)};
        return codes;
    endfunction

    task automatic send_row(t_code_q codes);
        foreach (codes[i])
            send_item(CMD_CODEWORD, codes[i]);
        send_item(CMD_END_ROW, rand_code());
    endtask

    // Scan one symbol; rescans are common, noise is mixed in when asked
    task automatic scan_symbol(int n_rows, int width, bit noisy);
        t_code_q row;
        t_code_q bad;
        t_code_q last_good;
        t_cw     set_code;
        int      claimed;
        int      pick;
        claimed = (noisy && $urandom_range(0, 9) == 0) ? n_rows + 1 : n_rows;
        for (int r = 0; r < n_rows; r++) begin
            set_code = pick_set();
            if (r == 0)
                row = build_row(set_code, total_code(set_code, claimed), width);
            else if (noisy && $urandom_range(0, 24) == 0)
                row = build_row(set_code, index_code(set_code, r + 1), width);
            else
                row = build_row(set_code, index_code(set_code, r), width);
            if (noisy) begin
                case ($urandom_range(0, 15))
                    0: begin
                        bad = row;
                        pick = $urandom_range(0, bad.size() - 1);
                        bad[pick] = bad[pick] ^ t_cw'($urandom_range(1, 127));
                        send_row(bad);
                    end
                    1: begin
                        bad = {};
                        repeat ($urandom_range(0, MIN_ROW_LEN - 1))
                            bad = {bad, rand_code()};
                        send_row(bad);
                    end
                    2: send_item(CMD_UNUSED, rand_code());
                    3: if ($urandom_range(0, 3) == 0)
                        send_row(build_row(set_code, index_code(set_code, r),
                                           $urandom_range(MIN_ROW_LEN, ROW_CODES)));
                    4: if (last_good.size() > 0)
                        send_row(last_good);
                    5: if ($urandom_range(0, 3) == 0) begin
                        bad = {};
                        repeat ($urandom_range(ROW_CODES + 1, ROW_CODES + 6))
                            bad = {bad, rand_code()};
                        send_row(bad);
                    end
                    default: ;
                endcase
            end
            send_row(row);
            if ($urandom_range(0, 4) == 0)
                send_row(row);
            last_good = row;
        end
        // Leave a row unfinished now and then
        if (noisy && $urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 8)) send_item(CMD_CODEWORD, rand_code());
        send_item(CMD_END_SYMBOL, rand_code());
    endtask

    // Drop valid and wait until every queued report has come back
    task automatic wait_reports_drained();
        in_ch.valid = 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Empty, short and bad-checksum rows; a symbol with a single row
    task automatic test_row_rejects();
        t_code_q row;
        send_item(CMD_END_ROW, 7'd127);
        row = {};
        row = {row, 7'd127};
        row = {row, 7'd0};
        row = {row, 7'd105};
        row = {row, 7'd64};
        row = {row, 7'd1};
        send_row(row);
        row = {};
        repeat (MIN_ROW_LEN) row = {row, 7'd0};
        send_row(row);
        row = {};
        repeat (MIN_ROW_LEN - 1) row = {row, 7'd105};
        row = {row, weighted_sum(row) ^ 7'd1};
        send_row(row);
        send_item(CMD_END_SYMBOL, 7'd0);
        send_item(CMD_END_SYMBOL, 7'd127);
    endtask

    // Minimal good symbol with a rescan, an ignored command and a trailing partial row
    task automatic test_good_symbol();
        t_code_q first;
        t_code_q second;
        first  = build_row(CODE_SET_C, total_code(CODE_SET_C, 2), MIN_ROW_LEN);
        second = build_row(7'd101, index_code(7'd101, 1), MIN_ROW_LEN);
        send_row(first);
        send_row(first);
        send_item(CMD_UNUSED, 7'd127);
        send_row(second);
        send_item(CMD_CODEWORD, 7'd99);
        send_item(CMD_CODEWORD, 7'd12);
        send_item(CMD_END_SYMBOL, 7'd0);
    endtask

    // Size mismatch, wrong row total, wrong row index
    task automatic test_symbol_errors();
        send_row(build_row(7'd5, total_code(7'd5, 2), MIN_ROW_LEN));
        send_row(build_row(7'd5, index_code(7'd5, 1), MIN_ROW_LEN + 1));
        send_item(CMD_END_SYMBOL, 7'd0);
        send_row(build_row(CODE_SET_C, total_code(CODE_SET_C, 3), MIN_ROW_LEN));
        send_row(build_row(CODE_SET_C, index_code(CODE_SET_C, 1), MIN_ROW_LEN));
        send_item(CMD_END_SYMBOL, 7'd0);
        send_row(build_row(7'd64, total_code(7'd64, 2), MIN_ROW_LEN));
        send_row(build_row(7'd64, index_code(7'd64, 2), MIN_ROW_LEN));
        send_item(CMD_END_SYMBOL, 7'd0);
    endtask

    // Full-width rows and overlong rows
    task automatic test_long_rows();
        t_code_q row;
        send_row(build_row(7'd0, total_code(7'd0, 2), ROW_CODES));
        row = {};
        repeat (ROW_CODES + 1) row = {row, rand_code()};
        send_row(row);
        send_row(build_row(7'd127, index_code(7'd127, 1), ROW_CODES));
        row = {};
        repeat (ROW_CODES + 7) row = {row, rand_code()};
        send_row(row);
        send_item(CMD_END_SYMBOL, 7'd0);
    endtask

    // Fill the symbol to the row limit, then offer one row more
    task automatic test_row_limit();
        send_row(build_row(CODE_SET_C, total_code(CODE_SET_C, ROW_LIMIT), MIN_ROW_LEN));
        for (int r = 1; r < ROW_LIMIT; r++)
            send_row(build_row(CODE_SET_C, index_code(CODE_SET_C, r), MIN_ROW_LEN));
        send_row(build_row(CODE_SET_C, index_code(CODE_SET_C, ROW_LIMIT), MIN_ROW_LEN));
        send_item(CMD_END_SYMBOL, 7'd0);
    endtask

    // Hold the result side off while the sender keeps offering rows
    task automatic test_output_backpressure();
        in_idle_on    = 1'b0;
        out_idle_on   = 1'b0;
        long_hold_req = 1'b1;
        scan_symbol(4, MIN_ROW_LEN, 1'b0);
        scan_symbol(3, MIN_ROW_LEN + 2, 1'b0);
        in_idle_on  = 1'b1;
        out_idle_on = 1'b1;
    endtask

    // Random symbols, mostly well-formed, with noise and broken scans mixed in
    task automatic test_random_symbols(int item_goal);
        int n_rows;
        int width;
        int goal;
        goal = accepted_items + item_goal;
        while (accepted_items < goal) begin
            in_idle_on  = $urandom_range(0, 3) != 0;
            out_idle_on = $urandom_range(0, 3) != 0;
            case ($urandom_range(0, 9))
                0: n_rows = $urandom_range(0, 1);
                1: n_rows = $urandom_range(6, 45);
                default: n_rows = $urandom_range(2, 5);
            endcase
            if ($urandom_range(0, 15) == 0)
                width = $urandom_range(13, ROW_CODES);
            else
                width = $urandom_range(MIN_ROW_LEN, 12);
            if (n_rows > 20 && width > 16)
                width = $urandom_range(MIN_ROW_LEN, 16);
            scan_symbol(n_rows, width, $urandom_range(0, 9) < 7);
        end
    endtask

    // Back-to-back traffic with no idling on either side
    task automatic test_steady_stream();
        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
        repeat (4)
            scan_symbol($urandom_range(2, 6), $urandom_range(MIN_ROW_LEN, 10), 1'b1);
    endtask

    initial begin : run_tests
        in_ch.valid    = 1'b0;
        in_ch.command  = CMD_CODEWORD;
        in_ch.codeword = '0;
        fill_bank      = 1'b0;
        clear_symbol_state();
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        test_row_rejects();
        test_good_symbol();
        test_symbol_errors();
        test_long_rows();
        test_row_limit();
        test_output_backpressure();
        test_random_symbols(RANDOM_ITEMS);
        test_steady_stream();

        wait_reports_drained();
        if (mismatch_count == 0)
            $display("stacked_barcode_row_validator_unit_tb passed");
        else
            $display("stacked_barcode_row_validator_unit_tb failed");
        $finish;
    end

endmodule
